[rtl/jsu_pkg.sv]
// Types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_STR     = 7'b0000010,
      PH_ESC     = 7'b0000100,
      PH_HEX1    = 7'b0001000,
      PH_WANT_BS = 7'b0010000,
      PH_WANT_U  = 7'b0100000,
      PH_HEX2    = 7'b1000000
   } phase_type;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
   localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
   localparam logic [2:0] ERR_UNPAIRED  = 3'd3;
   localparam logic [2:0] ERR_BAD_LOW   = 3'd4;
   localparam logic [2:0] ERR_ORPHAN    = 3'd5;
   localparam logic [2:0] ERR_EOT       = 3'd6;
   localparam logic [2:0] ERR_EARLY_END = 3'd7;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_EOT   = 8'h04;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] PLANE_BASE = 21'h10000;

   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] CONT  = 8'h80;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_digit_type;

   function automatic hex_digit_type hex_val(input logic [7:0] c);
      hex_digit_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.val = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel req_*: one byte of JSON text per transaction in req_tdata;
// req_tlast high marks the end of input, and the byte is then ignored.
// Result channel rsp_*: one result per transaction. rsp_tdata is the
// decoded byte, rsp_tuser carries the kind (byte, string closed, error) and the
// error code, rsp_tlast marks the final result of one input byte.
// An input byte is held in an input register, decoded in a single pass and
// its 0 to 4 results loaded into a burst register that drains one result
// per cycle while rsp_tready is high. A result passes the input register
// and then the burst register. Plain bytes flow one per cycle when ready;
// the n UTF-8 bytes of a \u escape hold the port until all have drained.
// When the receiver stalls, the burst holds; bytes that yield no result
// still advance, and the first byte that yields a result waits in the
// input register while req_tready drops.
// Reset (synchronous, active high) returns the decoder to idle, waiting for
// an opening quote, and discards any held byte and pending results.
module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // stream_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [4:0] rsp_tuser,   // [1:0] kind, [4:2] error_code
   output logic       rsp_tlast    // last
);

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [9:0]  high_ff, high_in;

   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  burst_ff [4];
   logic [7:0]  burst_in [4];
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  code_ff, code_in;

   logic [2:0]  dec_n;
   logic [7:0]  dec_b [4];
   logic [1:0]  dec_kind;
   logic [2:0]  dec_code;

   hex_digit_type hd;
   logic [15:0] accum_next;
   logic [20:0] cp;
   logic        emit_cp;
   logic        out_free, rsp_fire, move;

   always_comb begin
      hd         = hex_val(in_byte_ff);
      accum_next = {accum_ff[11:0], hd.val};
      phase_in   = phase_ff;
      accum_in   = accum_ff;
      count_in   = count_ff;
      high_in    = high_ff;
      dec_n      = 3'd0;
      dec_kind   = KIND_BYTE;
      dec_code   = ERR_NONE;
      dec_b[0]   = 8'd0;
      dec_b[1]   = 8'd0;
      dec_b[2]   = 8'd0;
      dec_b[3]   = 8'd0;
      emit_cp    = 1'b0;
      cp         = {5'd0, accum_next};
      if (in_end_ff) begin
         if (phase_ff != PH_IDLE && phase_ff != PH_STR && phase_ff != PH_ESC &&
             phase_ff != PH_HEX1 && phase_ff != PH_WANT_BS &&
             phase_ff != PH_WANT_U && phase_ff != PH_HEX2) begin
            phase_in = PH_IDLE;
         end else if (phase_ff != PH_IDLE) begin
            dec_n    = 3'd1;
            dec_kind = KIND_ERROR;
            dec_code = ERR_EARLY_END;
         end
      end else begin
         case (phase_ff)
            PH_STR: begin
               if (in_byte_ff == CH_BSL) begin
                  phase_in = PH_ESC;
               end else if (in_byte_ff == CH_EOT) begin
                  dec_n    = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_EOT;
               end else if (in_byte_ff == CH_QUOTE) begin
                  phase_in = PH_IDLE;
                  dec_n    = 3'd1;
                  dec_kind = KIND_CLOSE;
               end else begin
                  dec_n    = 3'd1;
                  dec_b[0] = in_byte_ff;
               end
            end
            PH_ESC: begin
               phase_in = PH_STR;
               dec_n    = 3'd1;
               case (in_byte_ff)
                  CH_B:    dec_b[0] = 8'h08;
                  CH_F:    dec_b[0] = 8'h0C;
                  CH_N:    dec_b[0] = 8'h0A;
                  CH_R:    dec_b[0] = 8'h0D;
                  CH_T:    dec_b[0] = 8'h09;
                  CH_U: begin
                     phase_in = PH_HEX1;
                     accum_in = 16'd0;
                     count_in = 2'd0;
                     dec_n    = 3'd0;
                  end
                  default: dec_b[0] = in_byte_ff;
               endcase
            end
            PH_HEX1, PH_HEX2: begin
               if (!hd.ok) begin
                  dec_n    = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_BAD_HEX;
               end else if (count_ff != 2'd3) begin
                  accum_in = accum_next;
                  count_in = count_ff + 2'd1;
               end else begin
                  accum_in = 16'd0;
                  count_in = 2'd0;
                  if (phase_ff == PH_HEX1) begin
                     if (accum_next >= HIGH_FIRST && accum_next <= HIGH_LAST) begin
                        high_in  = accum_next[9:0];
                        phase_in = PH_WANT_BS;
                     end else if (accum_next >= LOW_FIRST && accum_next <= LOW_LAST) begin
                        dec_n    = 3'd1;
                        dec_kind = KIND_ERROR;
                        dec_code = ERR_ORPHAN;
                     end else begin
                        phase_in = PH_STR;
                        emit_cp  = 1'b1;
                     end
                  end else if (accum_next < LOW_FIRST || accum_next > LOW_LAST) begin
                     dec_n    = 3'd1;
                     dec_kind = KIND_ERROR;
                     dec_code = ERR_BAD_LOW;
                  end else begin
                     phase_in = PH_STR;
                     emit_cp  = 1'b1;
                     cp       = PLANE_BASE + {1'b0, high_ff, accum_next[9:0]};
                  end
               end
            end
            PH_WANT_BS: begin
               if (in_byte_ff != CH_BSL) begin
                  dec_n    = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_UNPAIRED;
               end else begin
                  phase_in = PH_WANT_U;
               end
            end
            PH_WANT_U: begin
               if (in_byte_ff != CH_U) begin
                  dec_n    = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_UNPAIRED;
               end else begin
                  phase_in = PH_HEX2;
                  accum_in = 16'd0;
                  count_in = 2'd0;
               end
            end
            default: begin
               if (in_byte_ff == CH_QUOTE) begin
                  phase_in = PH_STR;
               end else begin
                  dec_n    = 3'd1;
                  dec_kind = KIND_ERROR;
                  dec_code = ERR_NO_QUOTE;
               end
            end
         endcase
      end
      if (dec_kind == KIND_ERROR) begin
         phase_in = PH_IDLE;
         accum_in = 16'd0;
         count_in = 2'd0;
      end
      if (emit_cp) begin
         if (cp < 21'h80) begin
            dec_n    = 3'd1;
            dec_b[0] = cp[7:0];
         end else if (cp < 21'h800) begin
            dec_n    = 3'd2;
            dec_b[0] = LEAD2 | {3'd0, cp[10:6]};
            dec_b[1] = CONT | {2'd0, cp[5:0]};
         end else if (cp < PLANE_BASE) begin
            dec_n    = 3'd3;
            dec_b[0] = LEAD3 | {4'd0, cp[15:12]};
            dec_b[1] = CONT | {2'd0, cp[11:6]};
            dec_b[2] = CONT | {2'd0, cp[5:0]};
         end else begin
            dec_n    = 3'd4;
            dec_b[0] = LEAD4 | {5'd0, cp[20:18]};
            dec_b[1] = CONT | {2'd0, cp[17:12]};
            dec_b[2] = CONT | {2'd0, cp[11:6]};
            dec_b[3] = CONT | {2'd0, cp[5:0]};
         end
      end
   end

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign out_free   = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_tready);
   assign move       = in_vld_ff && (dec_n == 3'd0 || out_free);
   assign req_tready = !in_vld_ff || move;
   assign in_vld_in  = req_tvalid ? 1'b1 : (in_vld_ff && !move);

   always_comb begin
      cnt_in      = cnt_ff;
      kind_in     = kind_ff;
      code_in     = code_ff;
      burst_in[0] = burst_ff[0];
      burst_in[1] = burst_ff[1];
      burst_in[2] = burst_ff[2];
      burst_in[3] = burst_ff[3];
      if (move && dec_n != 3'd0) begin
         cnt_in      = dec_n;
         kind_in     = dec_kind;
         code_in     = dec_code;
         burst_in[0] = dec_b[0];
         burst_in[1] = dec_b[1];
         burst_in[2] = dec_b[2];
         burst_in[3] = dec_b[3];
      end else if (rsp_fire) begin
         cnt_in      = cnt_ff - 3'd1;
         burst_in[0] = burst_ff[1];
         burst_in[1] = burst_ff[2];
         burst_in[2] = burst_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff  <= PH_IDLE;
         accum_ff  <= 16'd0;
         count_ff  <= 2'd0;
         high_ff   <= 10'd0;
         cnt_ff    <= 3'd0;
      end else begin
         in_vld_ff <= req_tready ? in_vld_in : in_vld_ff;
         cnt_ff    <= cnt_in;
         if (move) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            count_ff <= count_in;
            high_ff  <= high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      burst_ff[0] <= burst_in[0];
      burst_ff[1] <= burst_in[1];
      burst_ff[2] <= burst_in[2];
      burst_ff[3] <= burst_in[3];
   end

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = burst_ff[0];
   assign rsp_tuser  = {code_ff, kind_ff};
   assign rsp_tlast  = (cnt_ff == 3'd1);

`ifndef SYNTHESIS
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result burst count out of range");

   a_single_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind_ff != KIND_BYTE |-> rsp_tlast && burst_ff[0] == 8'd0)
      else $error("close or error result is not a single zero-byte result");

   a_code_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind_ff != KIND_ERROR |-> code_ff == ERR_NONE)
      else $error("error code set on a non-error result");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !move |=> in_vld_ff && $stable(in_byte_ff) && $stable(phase_ff))
      else $error("held input byte or phase changed without decode");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");
`endif

endmodule
